// ===== rtl/arp_resolution_engine_unit_macros.svh =====
// assertion macros for the address resolution engine
`ifndef ARP_RESOLUTION_ENGINE_UNIT_MACROS_SVH
`define ARP_RESOLUTION_ENGINE_UNIT_MACROS_SVH

`define ARP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/arp_pkg.sv =====
// shared types and constants of the address resolution engine
package arp_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = 4;

   localparam logic [1:0] FUNC_RESOLVE = 2'd0;
   localparam logic [1:0] FUNC_PACKET  = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;

   localparam logic [15:0] HW_ETHERNET = 16'd1;
   localparam logic [15:0] OP_REQUEST  = 16'd1;
   localparam logic [15:0] OP_REPLY    = 16'd2;

   localparam logic [1:0] CMD_RESOLVE = 2'd0;
   localparam logic [1:0] CMD_ANSWER  = 2'd1;
   localparam logic [1:0] CMD_FILL    = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam logic [2:0] KIND_HIT      = 3'd0;
   localparam logic [2:0] KIND_SEND_REQ = 3'd1;
   localparam logic [2:0] KIND_SEND_REP = 3'd2;
   localparam logic [2:0] KIND_RESOLVED = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
   localparam logic [2:0] KIND_FULL     = 3'd5;

   localparam logic [1:0] CSR_OUR_MAC = 2'd0;
   localparam logic [1:0] CSR_OUR_IP  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd250;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] ip;
      logic [47:0] mac;
   } arp_cmd_type;

endpackage

// ===== rtl/arp_front.sv =====
// request decode and two-entry command queue
module arp_front import arp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_query_ip,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_operation,
   input  logic [47:0] req_sender_mac,
   input  logic [31:0] req_sender_ip,
   input  logic [47:0] req_target_mac,
   input  logic [31:0] req_target_ip,
   input  logic [47:0] our_mac,
   input  logic [31:0] our_ip,
   output logic        q_valid,
   output arp_cmd_type q_head,
   input  logic        q_pop
);

   arp_cmd_type q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        keep;
   arp_cmd_type cmd;
   logic        push;

   always_comb begin
      keep    = 1'b0;
      cmd.cmd = CMD_RESOLVE;
      cmd.ip  = req_sender_ip;
      cmd.mac = req_sender_mac;
      unique case (req_func)
         FUNC_RESOLVE: begin
            keep   = 1'b1;
            cmd.ip = req_query_ip;
         end
         FUNC_PACKET: begin
            if (req_hw_type == HW_ETHERNET) begin
               if (req_operation == OP_REQUEST && req_target_ip == our_ip) begin
                  keep    = 1'b1;
                  cmd.cmd = CMD_ANSWER;
               end else if (req_operation == OP_REPLY && req_target_mac == our_mac) begin
                  keep    = 1'b1;
                  cmd.cmd = CMD_FILL;
               end
            end
         end
         FUNC_TICK: begin
            keep    = 1'b1;
            cmd.cmd = CMD_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall = count_ff[1];
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = count_ff != 2'd0;
   assign q_head    = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cmd;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

// ===== rtl/arp_back.sv =====
// cache and pending tables, command execution and result register
module arp_back import arp_pkg::*; #(
   parameter int CACHE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  arp_cmd_type q_head,
   output logic        q_pop,
   input  logic [15:0] timeout_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_result_ip,
   output logic [47:0] rsp_result_mac,
   output logic        rsp_last
);

   `include "arp_resolution_engine_unit_macros.svh"

   localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [CACHE_DEPTH-1:0]   cache_valid_ff;
   logic [31:0]              cache_ip_ff  [CACHE_DEPTH];
   logic [47:0]              cache_mac_ff [CACHE_DEPTH];
   logic [CW-1:0]            next_slot_ff;
   logic [PENDING_DEPTH-1:0] pend_valid_ff;
   logic [31:0]              pend_ip_ff  [PENDING_DEPTH];
   logic [15:0]              pend_age_ff [PENDING_DEPTH];

   logic             state_ff, state_in;
   logic [PW-1:0]    scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0] scan_n_ff, scan_n_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [31:0] rsp_ip_ff;
   logic [47:0] rsp_mac_ff;
   logic        rsp_last_ff;

   logic                     cache_hit, pend_free, pend_hit, due_above;
   logic [CW-1:0]            cache_idx;
   logic [PW-1:0]            free_idx, pend_idx;
   logic [PENDING_DEPTH-1:0] due;
   logic                     out_free, emit, emit_last;
   logic [2:0]               emit_kind;
   logic [31:0]              emit_ip;
   logic [47:0]              emit_mac;
   logic                     open_pend, close_pend, cache_wr, slot_adv, age_inc, tick_close;
   logic [CW-1:0]            cache_wr_idx;

   always_comb begin
      cache_hit = 1'b0;
      cache_idx = '0;
      for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
         if (cache_valid_ff[i] && cache_ip_ff[i] == q_head.ip) begin
            cache_hit = 1'b1;
            cache_idx = CW'(i);
         end
      end
      pend_free = 1'b0;
      free_idx  = '0;
      pend_hit  = 1'b0;
      pend_idx  = '0;
      for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
         if (!pend_valid_ff[i]) begin
            pend_free = 1'b1;
            free_idx  = PW'(i);
         end
         if (pend_valid_ff[i] && pend_ip_ff[i] == q_head.ip) begin
            pend_hit = 1'b1;
            pend_idx = PW'(i);
         end
      end
      due_above = 1'b0;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
         due[i] = pend_valid_ff[i] && pend_age_ff[i] >= timeout_ticks;
         if (due[i] && PW'(i) > scan_idx_ff) due_above = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      scan_n_in    = scan_n_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_last    = 1'b1;
      emit_kind    = KIND_HIT;
      emit_ip      = q_head.ip;
      emit_mac     = '0;
      open_pend    = 1'b0;
      close_pend   = 1'b0;
      cache_wr     = 1'b0;
      slot_adv     = 1'b0;
      age_inc      = 1'b0;
      tick_close   = 1'b0;
      cache_wr_idx = cache_hit ? cache_idx : next_slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_head.cmd)
                  CMD_RESOLVE: begin
                     emit = 1'b1;
                     if (cache_hit) begin
                        emit_mac = cache_mac_ff[cache_idx];
                     end else if (pend_free) begin
                        emit_kind = KIND_SEND_REQ;
                        open_pend = 1'b1;
                     end else begin
                        emit_kind = KIND_FULL;
                     end
                  end
                  CMD_ANSWER: begin
                     emit      = 1'b1;
                     emit_kind = KIND_SEND_REP;
                     emit_mac  = q_head.mac;
                  end
                  CMD_FILL: begin
                     if (pend_hit) begin
                        emit       = 1'b1;
                        emit_kind  = KIND_RESOLVED;
                        emit_mac   = q_head.mac;
                        close_pend = 1'b1;
                        cache_wr   = 1'b1;
                        slot_adv   = !cache_hit;
                     end
                  end
                  CMD_TICK: begin
                     state_in    = ST_SCAN;
                     scan_idx_in = '0;
                     scan_n_in   = '0;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (due[scan_idx_ff] && scan_n_ff < CNT_W'(MAX_RESULTS)) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_kind  = KIND_TIMEOUT;
                  emit_ip    = pend_ip_ff[scan_idx_ff];
                  emit_last  = scan_n_ff == CNT_W'(MAX_RESULTS - 1) || !due_above;
                  tick_close = 1'b1;
                  scan_n_in  = scan_n_ff + 1'b1;
               end
            end else begin
               age_inc = pend_valid_ff[scan_idx_ff] && !due[scan_idx_ff];
            end
            if (age_inc || tick_close || !due[scan_idx_ff]
                || scan_n_ff >= CNT_W'(MAX_RESULTS)) begin
               if (scan_idx_ff == PW'(PENDING_DEPTH - 1)) state_in = ST_IDLE;
               else scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (open_pend) begin
         pend_ip_ff[free_idx]  <= q_head.ip;
         pend_age_ff[free_idx] <= '0;
      end
      if (age_inc) pend_age_ff[scan_idx_ff] <= pend_age_ff[scan_idx_ff] + 16'd1;
      if (cache_wr) begin
         cache_ip_ff[cache_wr_idx]  <= q_head.ip;
         cache_mac_ff[cache_wr_idx] <= q_head.mac;
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_ip_ff   <= emit_ip;
         rsp_mac_ff  <= emit_mac;
         rsp_last_ff <= emit_last;
      end
      if (reset) begin
         cache_valid_ff <= '0;
         pend_valid_ff  <= '0;
         next_slot_ff   <= '0;
         state_ff       <= ST_IDLE;
         scan_idx_ff    <= '0;
         scan_n_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         scan_n_ff   <= scan_n_in;
         if (open_pend) pend_valid_ff[free_idx] <= 1'b1;
         if (close_pend) pend_valid_ff[pend_idx] <= 1'b0;
         if (tick_close) pend_valid_ff[scan_idx_ff] <= 1'b0;
         if (cache_wr) cache_valid_ff[cache_wr_idx] <= 1'b1;
         if (slot_adv) begin
            if (next_slot_ff == CW'(CACHE_DEPTH - 1)) next_slot_ff <= '0;
            else next_slot_ff <= next_slot_ff + 1'b1;
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_result_ip  = rsp_ip_ff;
   assign rsp_result_mac = rsp_mac_ff;
   assign rsp_last       = rsp_last_ff;

   `ARP_ASSERT_NOW(a_no_pop_in_scan, state_ff == ST_SCAN, !q_pop, "queue popped during tick scan")
   `ARP_ASSERT_NOW(a_count_cap, state_ff == ST_SCAN, scan_n_ff <= CNT_W'(MAX_RESULTS), "too many timeouts")
   `ARP_ASSERT_NEXT(a_last_ends, state_ff == ST_SCAN && emit && emit_last && scan_idx_ff == PW'(PENDING_DEPTH - 1), state_ff == ST_IDLE, "scan did not end")
   `ARP_ASSERT_NOW(a_emit_room, emit, out_free, "result dropped")

endmodule

// ===== rtl/arp_resolution_engine_unit.sv =====
// top level of the address resolution engine
// usage:
//   requests enter on req_* (valid/stall): func 0 resolves query_ip, func 1 carries a
//   received packet, func 2 is an aging tick. results leave on rsp_* (valid/stall),
//   rsp_last marks the final result of a request; requests that cause no result
//   produce nothing. csr_we writes csr_data to register csr_index (0 own mac, 1 own
//   ip, 2 timeout in ticks); use only while idle, which the block does not enforce.
// timing:
//   a request enters a two-entry queue in the cycle it is offered; the executor
//   drains it one command per cycle while no tick scan runs and the output is free;
//   lookup or packet results pass the queue and the result register, one per cycle
//   when nothing stalls. a tick walks the pending table one entry per cycle, holding
//   at a due entry while output stalls, giving at most eight timeouts in index order.
// reset clears cache and pending valid bits, the ring slot, and sets the timeout to
//   250; no clearing pass is needed. when rsp_stall is high and a result is held,
//   that result holds and the executor waits; once the queue is full req_stall rises.
module arp_resolution_engine_unit import arp_pkg::*; #(
   parameter int CACHE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_query_ip,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_operation,
   input  logic [47:0] req_sender_mac,
   input  logic [31:0] req_sender_ip,
   input  logic [47:0] req_target_mac,
   input  logic [31:0] req_target_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_result_ip,
   output logic [47:0] rsp_result_mac,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] our_mac_ff;
   logic [31:0] our_ip_ff;
   logic [15:0] timeout_ff;
   logic        q_valid, q_pop;
   arp_cmd_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         our_mac_ff <= '0;
         our_ip_ff  <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OUR_MAC: our_mac_ff <= csr_data;
            CSR_OUR_IP:  our_ip_ff  <= csr_data[31:0];
            CSR_TIMEOUT: timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   arp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_query_ip, .req_hw_type,
      .req_operation, .req_sender_mac, .req_sender_ip, .req_target_mac, .req_target_ip,
      .our_mac(our_mac_ff), .our_ip(our_ip_ff), .q_valid, .q_head, .q_pop
   );

   arp_back #(.CACHE_DEPTH(CACHE_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_head, .q_pop, .timeout_ticks(timeout_ff),
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_result_ip, .rsp_result_mac, .rsp_last
   );

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the address resolution engine: directed and random requests
`timescale 1ns / 1ps

module tb;
   import arp_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int CACHE_N   = 16;
   localparam int PENDING_N = 8;
   localparam int POOL_N    = 24;
   localparam int SETTLE    = 24;
   localparam int LIMIT     = 400000;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] query_ip;
      logic [15:0] hw_type;
      logic [15:0] operation;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [47:0] target_mac;
      logic [31:0] target_ip;
   } request_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] ip;
      logic [47:0] mac;
      logic        last;
   } answer_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_func;
   logic [31:0] req_query_ip, req_sender_ip, req_target_ip;
   logic [15:0] req_hw_type, req_operation;
   logic [47:0] req_sender_mac, req_target_mac;
   logic        rsp_valid, rsp_stall;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_result_ip;
   logic [47:0] rsp_result_mac;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [47:0] csr_data;

   arp_resolution_engine_unit dut (.*);

   // mirrored engine state
   logic [47:0] own_mac;
   logic [31:0] own_ip;
   logic [15:0] timeout_limit;
   logic        cache_v [CACHE_N];
   logic [31:0] cache_ip [CACHE_N];
   logic [47:0] cache_mac [CACHE_N];
   logic [3:0]  ring_slot;
   logic        pend_v [PENDING_N];
   logic [31:0] pend_ip [PENDING_N];
   logic [15:0] pend_age [PENDING_N];

   answer_type  answers_due [$];
   logic [31:0] ip_pool [POOL_N];
   int          mismatches;
   int          cycles;
   int          send_idle_pct, recv_idle_pct;
   int          hold_left;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      if (hold_left > 0) hold_left--;
   end

   task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report("unexpected result kind", 48'(rsp_kind), 48'd0);
         end else begin
            a = answers_due.pop_front();
            if (rsp_kind !== a.kind) report("kind", 48'(rsp_kind), 48'(a.kind));
            if (rsp_result_ip !== a.ip) report("ip", 48'(rsp_result_ip), 48'(a.ip));
            if (rsp_result_mac !== a.mac) report("mac", rsp_result_mac, a.mac);
            if (rsp_last !== a.last) report("last", 48'(rsp_last), 48'(a.last));
         end
      end
   end

   function automatic answer_type mk(input logic [2:0] k, input logic [31:0] ip,
                                     input logic [47:0] mac);
      answer_type a;
      a.kind = k; a.ip = ip; a.mac = mac; a.last = 1'b0;
      return a;
   endfunction

   function automatic void engine_step(input request_type r);
      answer_type out [$];
      int hit, slot;
      hit = -1;
      slot = -1;
      case (r.func)
         FUNC_RESOLVE: begin
            for (int i = CACHE_N - 1; i >= 0; i--)
               if (cache_v[i] && cache_ip[i] == r.query_ip) hit = i;
            for (int i = PENDING_N - 1; i >= 0; i--)
               if (!pend_v[i]) slot = i;
            if (hit >= 0) out.push_back(mk(KIND_HIT, r.query_ip, cache_mac[hit]));
            else if (slot >= 0) begin
               pend_v[slot] = 1'b1; pend_ip[slot] = r.query_ip; pend_age[slot] = 16'd0;
               out.push_back(mk(KIND_SEND_REQ, r.query_ip, 48'd0));
            end else out.push_back(mk(KIND_FULL, r.query_ip, 48'd0));
         end
         FUNC_PACKET: begin
            if (r.hw_type == HW_ETHERNET && r.operation == OP_REQUEST) begin
               if (r.target_ip == own_ip)
                  out.push_back(mk(KIND_SEND_REP, r.sender_ip, r.sender_mac));
            end else if (r.hw_type == HW_ETHERNET && r.operation == OP_REPLY &&
                         r.target_mac == own_mac) begin
               for (int i = PENDING_N - 1; i >= 0; i--)
                  if (pend_v[i] && pend_ip[i] == r.sender_ip) slot = i;
               if (slot >= 0) begin
                  pend_v[slot] = 1'b0;
                  for (int i = CACHE_N - 1; i >= 0; i--)
                     if (cache_v[i] && cache_ip[i] == r.sender_ip) hit = i;
                  if (hit >= 0) cache_mac[hit] = r.sender_mac;
                  else begin
                     cache_v[ring_slot] = 1'b1;
                     cache_ip[ring_slot] = r.sender_ip;
                     cache_mac[ring_slot] = r.sender_mac;
                     ring_slot = 4'(ring_slot + 4'd1);
                  end
                  out.push_back(mk(KIND_RESOLVED, r.sender_ip, r.sender_mac));
               end
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < PENDING_N; i++) begin
               if (pend_v[i]) begin
                  if (pend_age[i] >= timeout_limit) begin
                     if (out.size() < MAX_RESULTS) begin
                        out.push_back(mk(KIND_TIMEOUT, pend_ip[i], 48'd0));
                        pend_v[i] = 1'b0;
                     end
                  end else pend_age[i] = 16'(pend_age[i] + 16'd1);
               end
            end
         end
         default: ;
      endcase
      if (out.size() > 0) out[out.size() - 1].last = 1'b1;
      foreach (out[i]) answers_due.push_back(out[i]);
   endfunction

   task automatic send(input request_type r);
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) req_valid = 0;
         else break;
      end
      req_valid = 1;
      req_func = r.func; req_query_ip = r.query_ip;
      req_hw_type = r.hw_type; req_operation = r.operation;
      req_sender_mac = r.sender_mac; req_sender_ip = r.sender_ip;
      req_target_mac = r.target_mac; req_target_ip = r.target_ip;
      do @(posedge clock); while (req_stall);
      engine_step(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [47:0] value);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_data = value;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         CSR_OUR_MAC: own_mac = value;
         CSR_OUR_IP:  own_ip = value[31:0];
         CSR_TIMEOUT: timeout_limit = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic request_type blank(input logic [1:0] f);
      request_type r;
      r.func = f; r.query_ip = $urandom;
      r.hw_type = 16'($urandom); r.operation = 16'($urandom);
      r.sender_mac = rand48(); r.sender_ip = $urandom;
      r.target_mac = rand48(); r.target_ip = $urandom;
      return r;
   endfunction

   function automatic request_type resolve(input logic [31:0] ip);
      request_type r;
      r = blank(FUNC_RESOLVE);
      r.query_ip = ip;
      return r;
   endfunction

   function automatic request_type packet(input logic [15:0] op, input logic [31:0] sip,
                                          input logic [47:0] smac, input logic [47:0] tmac,
                                          input logic [31:0] tip);
      request_type r;
      r = blank(FUNC_PACKET);
      r.hw_type = HW_ETHERNET; r.operation = op;
      r.sender_ip = sip; r.sender_mac = smac; r.target_mac = tmac; r.target_ip = tip;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      logic [31:0] ip;
      pick = $urandom_range(99);
      ip = ip_pool[$urandom_range(POOL_N - 1)];
      if (pick < 38) r = resolve(($urandom_range(9) == 0) ? $urandom : ip);
      else if (pick < 63)
         r = packet(OP_REPLY, ip, rand48(),
                    ($urandom_range(7) == 0) ? rand48() : own_mac, $urandom);
      else if (pick < 73)
         r = packet(OP_REQUEST, $urandom, rand48(), rand48(),
                    ($urandom_range(3) == 0) ? $urandom : own_ip);
      else if (pick < 90) r = blank(FUNC_TICK);
      else begin
         r = blank(2'($urandom_range(3)));
         if ($urandom_range(1)) r.hw_type = HW_ETHERNET;
      end
      return r;
   endfunction

   task automatic test_reset_state();
      send(resolve(32'h0a000001));
      send(packet(OP_REQUEST, 32'hc0a80005, 48'h0200_0000_0005, 48'h0, 32'h0));
      send(blank(FUNC_TICK));
      drain();
   endtask

   task automatic test_register_extremes();
      csr_write(CSR_OUR_MAC, 48'hffff_ffff_ffff);
      csr_write(CSR_OUR_IP, 48'hffff_ffff);
      csr_write(CSR_TIMEOUT, 48'h0);
      csr_write(CSR_UNUSED, 48'h1234);
      send(packet(OP_REQUEST, 32'hffffffff, 48'hffff_ffff_ffff, 48'h0, 32'hffffffff));
      send(packet(OP_REPLY, 32'h0a000001, 48'h0, own_mac, 32'h0));
      send(resolve(32'h0a000001));
      send(blank(FUNC_TICK));
      drain();
      csr_write(CSR_TIMEOUT, 48'hffff);
      send(resolve(32'h0b000002));
      send(blank(FUNC_TICK));
      drain();
   endtask

   task automatic test_special_cases();
      request_type r;
      csr_write(CSR_OUR_MAC, 48'h0);
      csr_write(CSR_OUR_IP, 48'h0);
      csr_write(CSR_TIMEOUT, 48'h0);
      send(blank(FUNC_TICK));
      drain();
      csr_write(CSR_OUR_MAC, 48'h0200_1234_5678);
      csr_write(CSR_OUR_IP, 48'hc0a8_0001);
      csr_write(CSR_TIMEOUT, 48'h2);
      send(resolve(32'h0a000009));
      send(resolve(32'h0a000009));
      for (int i = 0; i < PENDING_N - 1; i++) send(resolve(32'(32'h0a000100 + i)));
      send(packet(OP_REPLY, 32'h0a000009, 48'h0200_0000_0009, own_mac, 32'h0));
      send(packet(OP_REPLY, 32'h0a000009, 48'h0200_0000_0019, own_mac, 32'h0));
      send(packet(OP_REPLY, 32'h0a000100, 48'h1, 48'h0200_0000_0001, 32'h0));
      send(packet(OP_REPLY, 32'h0a0000ff, 48'h1, own_mac, 32'h0));
      send(packet(OP_REQUEST, 32'h1, 48'h1, 48'h0, 32'hc0a80002));
      send(packet(16'h0003, 32'h1, 48'h1, own_mac, own_ip));
      r = packet(OP_REQUEST, 32'h1, 48'h1, 48'h0, own_ip);
      r.hw_type = 16'hffff;
      send(r);
      send(blank(FUNC_UNUSED));
      send(resolve(32'h0a000009));
      repeat (4) send(blank(FUNC_TICK));
      drain();
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 200;
      for (int i = 0; i < 20; i++) send(resolve(ip_pool[i % 4]));
      drain();
      for (int i = 0; i < 10; i++) send(random_request());
      drain();
   endtask

   task automatic test_random_mix(input int count, input int s_pct, input int r_pct,
                                  input logic [15:0] tmo);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      csr_write(CSR_OUR_MAC, rand48());
      csr_write(CSR_OUR_IP, 48'($urandom));
      csr_write(CSR_TIMEOUT, 48'(tmo));
      for (int i = 0; i < count; i++) send(random_request());
      drain();
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_func = FUNC_RESOLVE; req_query_ip = 0;
      req_hw_type = 0; req_operation = 0; req_sender_mac = 0; req_sender_ip = 0;
      req_target_mac = 0; req_target_ip = 0;
      csr_we = 0; csr_index = CSR_OUR_MAC; csr_data = 0;
      rsp_stall = 0; hold_left = 0; mismatches = 0; cycles = 0;
      send_idle_pct = 28; recv_idle_pct = 72;
      own_mac = 0; own_ip = 0; timeout_limit = TIMEOUT_RESET; ring_slot = 0;
      foreach (cache_v[i]) begin
         cache_v[i] = 0; cache_ip[i] = 0; cache_mac[i] = 0;
      end
      foreach (pend_v[i]) begin
         pend_v[i] = 0; pend_ip[i] = 0; pend_age[i] = 0;
      end
      foreach (ip_pool[i]) ip_pool[i] = $urandom;
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hffffffff;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_reset_state();
      test_register_extremes();
      test_special_cases();
      test_backpressure();
      test_random_mix(50, 28, 72, 16'd3);
      test_random_mix(50, 72, 28, 16'd1);
      test_random_mix(50, 0, 0, 16'd6);

      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_back.sv
rtl/arp_resolution_engine_unit.sv
dv/tb.sv
